>>> hdl/bse_pkg.sv
// Package for the cubic spline evaluator: widths, mode codes, register address.
package bse_pkg;
  localparam int unsigned MaxPoints  = 64;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned IdxWidth   = $clog2(MaxPoints);
  localparam int unsigned CntWidth   = IdxWidth + 1;
  localparam int unsigned TWidth     = 17;
  localparam int unsigned InWidth    = 2 + IdxWidth + 5 * CoordWidth;
  localparam int unsigned InBytes    = (InWidth + 7) / 8;
  localparam int unsigned OutWidth   = 2 * CoordWidth + 1;
  localparam int unsigned OutBytes   = (OutWidth + 7) / 8;

  localparam logic [1:0] ModeWrite    = 2'd0;
  localparam logic [1:0] ModeEval     = 2'd1;
  localparam logic [1:0] ModeValidate = 2'd2;
  localparam logic [1:0] ModeReserved = 2'd3;

  localparam logic [0:0] RegPointCount = 1'd0;
endpackage

>>> hdl/bezier_spline_evaluator.sv
// Top level of the piecewise cubic Bezier spline evaluator.
//
// channel   | direction | handshake       | payload
// s_axis    | in        | tvalid/tready   | tdata: mode, point_index, point_x, point_y,
//           |           |                 |        handle_dx, handle_dy, query_x
// m_axis    | out       | tvalid/tready   | tdata: curve_x, curve_y, status
// apb       | in        | psel/penable    | point_count at address 0
//
// One item at a time; tready is low while an item is at work. Validate walks the
// table once, one entry read per cycle (up to 64). Evaluate adds a second walk for
// the segment, a 17-step restoring divider for t, and six lerps on one shared
// 33x17 multiplier, each lerp done for x and then for y.
// The result sits in an output register; the next item is taken when it drains.
// Reset clears control state and point_count; the table is not cleared.
module bezier_spline_evaluator
  import bse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] mode, [7:2] point_index, [39:8] point_x, [71:40] point_y,
  // [103:72] handle_dx, [135:104] handle_dy, [167:136] query_x
  input  logic [8*InBytes-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] curve_x, [63:32] curve_y, [64] status
  output logic [8*OutBytes-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned W = CoordWidth;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StVal   = 4'd1;
  localparam logic [3:0] StFind  = 4'd2;
  localparam logic [3:0] StLoad  = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StLerp  = 4'd5;
  localparam logic [3:0] StOut   = 4'd6;
  localparam logic [3:0] StRd    = 4'd7;
  localparam logic [3:0] StClamp = 4'd8;

  logic [W-1:0] mem_px [MaxPoints];
  logic [W-1:0] mem_py [MaxPoints];
  logic [W-1:0] mem_hx [MaxPoints];
  logic [W-1:0] mem_hy [MaxPoints];

  logic [3:0]          state_q, state_d;
  logic [CntWidth-1:0] count_q;
  logic [CntWidth-1:0] n_act;
  logic [IdxWidth-1:0] ra_q, ra_d;
  logic [W-1:0]        rpx_q, rpy_q, rhx_q, rhy_q;
  logic                rd_pend_q;
  logic                mode_eval_q;
  logic [CntWidth-1:0] i_q;
  logic signed [W-1:0] prev_x_q, q_q;
  logic                bad_q;
  logic signed [W-1:0] px_q [4];
  logic signed [W-1:0] py_q [4];
  logic [1:0]          ld_q;
  logic [TWidth-1:0]   t_q;
  logic [W:0]          rem_q, den_q;
  logic [4:0]          dcnt_q;
  logic [2:0]          lv_q;
  logic [1:0]          lj_q;
  logic                ly_q;
  logic                ovalid_q;
  logic signed [W-1:0] ox_q, oy_q;
  logic                ostat_q;

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire [1:0] in_mode = s_axis_tdata[1:0];
  wire [IdxWidth-1:0] in_idx = s_axis_tdata[2+:IdxWidth];
  localparam int unsigned B = 2 + IdxWidth;

  assign pready = 1'b1;
  assign prdata = {{(32-CntWidth){1'b0}}, count_q};
  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign n_act = (count_q > CntWidth'(MaxPoints)) ? CntWidth'(MaxPoints) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegPointCount) begin
      count_q <= pwdata[CntWidth-1:0];
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (s_fire && in_mode == ModeWrite) begin
      mem_px[in_idx] <= s_axis_tdata[B+:W];
      mem_py[in_idx] <= s_axis_tdata[B+W+:W];
      mem_hx[in_idx] <= s_axis_tdata[B+2*W+:W];
      mem_hy[in_idx] <= s_axis_tdata[B+3*W+:W];
    end
    rpx_q <= mem_px[ra_d];
    rpy_q <= mem_py[ra_d];
    rhx_q <= mem_hx[ra_d];
    rhy_q <= mem_hy[ra_d];
  end

  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_add = s[W-1:0];
  endfunction

  // shared lerp unit: one multiply of |b-a| by t
  logic signed [W-1:0] la, lb, lres;
  logic [W:0]          ldiff;
  logic                lneg;
  logic [W+TWidth:0]   lprod;
  always_comb begin
    la = ly_q ? py_q[lj_q] : px_q[lj_q];
    lb = ly_q ? py_q[lj_q+2'd1] : px_q[lj_q+2'd1];
    lneg = $signed({lb[W-1], lb}) < $signed({la[W-1], la});
    ldiff = lneg ? ({la[W-1], la} - {lb[W-1], lb}) : ({lb[W-1], lb} - {la[W-1], la});
    lprod = ldiff * t_q + (lneg ? (W+TWidth+1)'(16'hFFFF) : '0);
    lres = lneg ? W'(la - W'(lprod >> 16)) : W'(la + W'(lprod >> 16));
  end

  // restoring divider step: shift the next numerator bit into the remainder
  logic [W:0]   dshift, dtry;
  logic [W-1:0] ld_num;
  assign dshift = {rem_q[W-1:0], ox_q[W-1]};
  assign dtry = dshift - den_q;
  assign ld_num = W'(q_q - rpx_q);

  always_comb begin
    state_d = state_q;
    ra_d = ra_q;
    unique case (state_q)
      StIdle: begin
        ra_d = '0;
        if (s_fire && (in_mode == ModeEval || in_mode == ModeValidate)) state_d = StRd;
      end
      StRd: begin
        ra_d = IdxWidth'(1);
        state_d = (n_act < CntWidth'(2)) ? StOut : StVal;
      end
      StVal: begin
        if (i_q == n_act - CntWidth'(1) || bad_q) begin
          state_d = (mode_eval_q && !bad_q && !($signed(rpx_q) < prev_x_q)) ?
                    StClamp : StOut;
          ra_d = '0;
        end else ra_d = IdxWidth'(i_q + CntWidth'(1));
      end
      StClamp: begin
        ra_d = '0;
        state_d = StFind;
      end
      StFind: begin
        ra_d = ra_q;
        if (i_q == '0) begin
          if (q_q < $signed(rpx_q)) state_d = StOut;
          else begin ra_d = IdxWidth'(n_act - CntWidth'(1)); end
        end else if (i_q == CntWidth'(1) && rd_pend_q) begin
          if (q_q > $signed(rpx_q)) state_d = StOut;
          else ra_d = IdxWidth'(1);
        end else if ($signed(rpx_q) >= q_q || i_q == n_act - CntWidth'(1)) begin
          ra_d = IdxWidth'(i_q - CntWidth'(1));
          state_d = StLoad;
        end else ra_d = IdxWidth'(i_q + CntWidth'(1));
      end
      StLoad: if (ld_q == 2'd1) state_d = StDiv;
      StDiv:  if (dcnt_q == 5'd0) state_d = StLerp;
      StLerp: if (lv_q == 3'd5 && ly_q) state_d = StOut;
      StOut:  if (!ovalid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovalid_q <= 1'b0;
      ra_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ra_q <= ra_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (state_q == StOut && !ovalid_q) ovalid_q <= 1'b1;
      if (state_q == StClamp) rd_pend_q <= 1'b0;
      else if (state_q == StFind && i_q == '0) rd_pend_q <= 1'b1;
      else if (state_q == StFind) rd_pend_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (s_fire) begin
        mode_eval_q <= in_mode == ModeEval;
        q_q <= s_axis_tdata[B+4*W+:W];
        bad_q <= 1'b0;
        i_q <= '0;
        ox_q <= '0;
        oy_q <= '0;
      end
      StRd: begin
        bad_q <= n_act < CntWidth'(2);
        ostat_q <= n_act < CntWidth'(2);
        i_q <= CntWidth'(1);
        prev_x_q <= rpx_q;
      end
      StVal: begin
        if ($signed(rpx_q) < prev_x_q) bad_q <= 1'b1;
        ostat_q <= $signed(rpx_q) < prev_x_q || bad_q;
        prev_x_q <= rpx_q;
        if (i_q == n_act - CntWidth'(1) || bad_q) i_q <= '0;
        else i_q <= i_q + CntWidth'(1);
      end
      StClamp: ;
      StFind: begin
        if (i_q == '0) begin
          ox_q <= rpx_q; oy_q <= rpy_q;
          i_q <= CntWidth'(1);
        end else if (i_q == CntWidth'(1) && rd_pend_q) begin
          ox_q <= rpx_q; oy_q <= rpy_q;
        end else if ($signed(rpx_q) >= q_q || i_q == n_act - CntWidth'(1)) begin
          px_q[3] <= rpx_q; py_q[3] <= rpy_q;
          px_q[2] <= sat_add(rpx_q, rhx_q); py_q[2] <= sat_add(rpy_q, rhy_q);
          ld_q <= 2'd0;
        end else i_q <= i_q + CntWidth'(1);
      end
      StLoad: begin
        ld_q <= ld_q + 2'd1;
        if (ld_q == 2'd1) begin
          px_q[0] <= rpx_q; py_q[0] <= rpy_q;
          px_q[1] <= sat_add(rpx_q, rhx_q); py_q[1] <= sat_add(rpy_q, rhy_q);
          t_q <= '0;
          dcnt_q <= 5'd16;
          // numerator: upper bits preload the remainder, the low bit waits in ox_q
          rem_q <= {2'b00, ld_num[W-1:1]};
          ox_q <= {ld_num[0], {(W-1){1'b0}}};
          // zero width forces t = 1
          if ($signed(px_q[3]) <= $signed(rpx_q)) begin
            den_q <= '0;
          end else begin
            den_q <= {1'b0, W'(px_q[3] - rpx_q)};
          end
        end
      end
      StDiv: begin
        // one quotient bit of num << 16 per cycle; with q in segment it fits 17 bits
        if (den_q == '0) begin
          t_q <= TWidth'(1 << 16);
          dcnt_q <= 5'd0;
        end else begin
          rem_q <= dtry[W] ? dshift : dtry;
          ox_q <= {ox_q[W-2:0], 1'b0};
          t_q <= {t_q[TWidth-2:0], !dtry[W]};
          dcnt_q <= dcnt_q - 5'd1;
        end
        lv_q <= '0; lj_q <= '0; ly_q <= 1'b0;
      end
      StLerp: begin
        if (ly_q) py_q[lj_q] <= lres; else px_q[lj_q] <= lres;
        ly_q <= !ly_q;
        if (ly_q) begin
          lv_q <= lv_q + 3'd1;
          lj_q <= (lv_q == 3'd2 || lv_q == 3'd4) ? 2'd0 : lj_q + 2'd1;
        end
        if (lv_q == 3'd5) begin
          if (ly_q) oy_q <= lres; else ox_q <= lres;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {{(8*OutBytes-OutWidth){1'b0}}, ostat_q, oy_q, ox_q};

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !s_axis_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLerp |-> t_q <= TWidth'(1 << 16)) else $error("t out of range");
`endif
endmodule

>>> tb/tb_bezier_spline_evaluator.sv
// Testbench for the cubic spline evaluator: stream stimulus, predicted results, APB setup.
`timescale 1ns / 1ps
module tb_bezier_spline_evaluator
  import bse_pkg::*;
();

  typedef struct packed {
    logic [31:0] query_x;
    logic [31:0] handle_dy;
    logic [31:0] handle_dx;
    logic [31:0] point_y;
    logic [31:0] point_x;
    logic [5:0]  point_index;
    logic [1:0]  mode;
  } spline_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] curve_y;
    logic [31:0] curve_x;
  } curve_point_t;

  localparam int unsigned CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [8*InBytes-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [8*OutBytes-1:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bezier_spline_evaluator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the point table and the count register
  longint shadow_x[MaxPoints], shadow_y[MaxPoints];
  longint shadow_dx[MaxPoints], shadow_dy[MaxPoints];
  int unsigned shadow_count;

  spline_item_t pending_items[$];
  curve_point_t expected_curve[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // a + floor((b - a) * t / 2^16), exact
  function automatic longint blend(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t;
    return a + (prod >>> 16);
  endfunction

  function automatic bit table_monotonic();
    int unsigned n;
    n = (shadow_count > MaxPoints) ? MaxPoints : shadow_count;
    if (n < 2) return 1'b0;
    for (int unsigned i = 1; i < n; i++)
      if (shadow_x[i] < shadow_x[i-1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic curve_point_t evaluate_curve(longint q);
    curve_point_t r;
    int unsigned n, seg;
    longint px[4], py[4], ax[3], ay[3], bx[2], by[2], den, t;
    n = (shadow_count > MaxPoints) ? MaxPoints : shadow_count;
    r.status = 1'b0;
    if (q < shadow_x[0]) begin
      r.curve_x = shadow_x[0][31:0];
      r.curve_y = shadow_y[0][31:0];
      return r;
    end
    if (q > shadow_x[n-1]) begin
      r.curve_x = shadow_x[n-1][31:0];
      r.curve_y = shadow_y[n-1][31:0];
      return r;
    end
    seg = n - 1;
    for (int unsigned i = 1; i < n - 1; i++)
      if (shadow_x[i] >= q) begin
        seg = i;
        break;
      end
    px[0] = shadow_x[seg-1];
    py[0] = shadow_y[seg-1];
    px[1] = clamp_coord(px[0] + shadow_dx[seg-1]);
    py[1] = clamp_coord(py[0] + shadow_dy[seg-1]);
    px[3] = shadow_x[seg];
    py[3] = shadow_y[seg];
    px[2] = clamp_coord(px[3] + shadow_dx[seg]);
    py[2] = clamp_coord(py[3] + shadow_dy[seg]);
    den = px[3] - px[0];
    if (den <= 0) t = 65536;
    else begin
      t = ((q - px[0]) <<< 16) / den;
      if (t > 65536) t = 65536;
    end
    for (int i = 0; i < 3; i++) begin
      ax[i] = blend(px[i], px[i+1], t);
      ay[i] = blend(py[i], py[i+1], t);
    end
    for (int i = 0; i < 2; i++) begin
      bx[i] = blend(ax[i], ax[i+1], t);
      by[i] = blend(ay[i], ay[i+1], t);
    end
    r.curve_x = 32'(blend(bx[0], bx[1], t));
    r.curve_y = 32'(blend(by[0], by[1], t));
    return r;
  endfunction

  // Advance the shadow by one accepted transaction and queue any result
  task automatic predict_item(spline_item_t it);
    curve_point_t r;
    bit ok;
    if (it.mode == ModeWrite) begin
      shadow_x[it.point_index]  = longint'($signed(it.point_x));
      shadow_y[it.point_index]  = longint'($signed(it.point_y));
      shadow_dx[it.point_index] = longint'($signed(it.handle_dx));
      shadow_dy[it.point_index] = longint'($signed(it.handle_dy));
      return;
    end
    if (it.mode != ModeEval && it.mode != ModeValidate) return;
    ok = table_monotonic();
    r = '0;
    r.status = !ok;
    if (it.mode == ModeEval && ok) r = evaluate_curve(longint'($signed(it.query_x)));
    expected_curve.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Capture the handshake at the rising edge so the driver sees it race-free
  logic s_axis_tready_q = 1'b0;
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) predict_item(spline_item_t'(s_axis_tdata));
  end

  // Driver: hold each transaction until accepted, insert random gaps
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        s_axis_tvalid <= 1'b0;
        send_gap = $urandom_range(0, 9);
      end else if (!s_axis_tvalid && send_gap > 0) begin
        send_gap--;
      end else if (!s_axis_tvalid && pending_items.size() > 0) begin
        s_axis_tdata <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: random stall on the result side, compare each result transaction
  logic m_fire_q = 1'b0;
  int unsigned recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_fire_q) begin
        recv_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    curve_point_t got, want;
    m_fire_q <= m_axis_tvalid && m_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got = curve_point_t'(m_axis_tdata[OutWidth-1:0]);
      if (expected_curve.size() == 0) begin
        report_mismatch("unexpected result", got.curve_x, '0);
      end else begin
        want = expected_curve.pop_front();
        if (got.curve_x !== want.curve_x) report_mismatch("curve_x", got.curve_x, want.curve_x);
        if (got.curve_y !== want.curve_y) report_mismatch("curve_y", got.curve_y, want.curve_y);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[bezier_spline_evaluator] ERROR");
      $finish;
    end
  end

  task automatic apb_write(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {RegPointCount, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow_count = value[6:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until the block has drained every queued item and result
  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_curve.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic spline_item_t point_write(int idx, longint x, longint y,
                                               longint dx, longint dy);
    spline_item_t it;
    it = '0;
    it.mode = ModeWrite; it.point_index = 6'(idx);
    it.point_x = 32'(x); it.point_y = 32'(y);
    it.handle_dx = 32'(dx); it.handle_dy = 32'(dy);
    it.query_x = $urandom;
    return it;
  endfunction

  function automatic spline_item_t query(logic [1:0] m, logic [31:0] q);
    spline_item_t it;
    it = '0;
    it.mode = m; it.query_x = q;
    it.point_index = 6'($urandom); it.point_x = $urandom; it.point_y = $urandom;
    it.handle_dx = $urandom; it.handle_dy = $urandom;
    return it;
  endfunction

  // Fill the table with a sorted set of n points, random content
  task automatic load_table(int n, int step_max);
    longint x;
    x = -longint'($urandom_range(0, 32'h4000_0000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) x = x; // repeated x gives a zero-width segment
      else x = x + $urandom_range(0, step_max);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      pending_items.push_back(point_write(i, x, $signed($urandom), $signed($urandom),
                                          $signed($urandom)));
    end
  endtask

  // Queries near the loaded table span
  function automatic logic [31:0] shadow_x_hint(int unsigned n);
    longint lo, hi;
    lo = shadow_x[0];
    hi = shadow_x[n-1];
    if (hi <= lo)
      return 32'(lo + longint'($urandom_range(0, 32'h00ff_ffff)) - 64'sh0080_0000);
    return 32'(lo + ((hi - lo) * longint'($urandom_range(0, 1100))) / 1000 - 16);
  endfunction

  int unsigned count_plan[$];
  int unsigned n_pts;

  initial begin
    shadow_count = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: invalid spline with count zero, then the extremes
    pending_items.push_back(query(ModeValidate, 0));
    pending_items.push_back(query(ModeEval, 32'h8000_0000));
    pending_items.push_back(point_write(0, -64'sd2147483648, 64'sd2147483647,
                                        64'sd2147483647, -64'sd2147483648));
    pending_items.push_back(point_write(1, 0, -64'sd2147483648, -64'sd2147483648,
                                        64'sd2147483647));
    pending_items.push_back(point_write(2, 0, 100, 0, 0));
    pending_items.push_back(point_write(3, 64'sd2147483647, 64'sd2147483647,
                                        64'sd2147483647, 64'sd2147483647));
    pending_items.push_back(query(ModeReserved, 0));
    drain();
    apb_write(4);
    pending_items.push_back(query(ModeValidate, 0));
    pending_items.push_back(query(ModeEval, 32'h8000_0000));
    pending_items.push_back(query(ModeEval, 32'h7fff_ffff));
    pending_items.push_back(query(ModeEval, 0));
    pending_items.push_back(query(ModeEval, 32'hc000_0000));
    pending_items.push_back(query(ModeEval, 32'h4000_0000));
    pending_items.push_back(query(ModeEval, 32'hffff_ffff));
    // Decreasing x makes the spline invalid
    pending_items.push_back(point_write(2, -5, 0, 0, 0));
    pending_items.push_back(query(ModeValidate, 0));
    pending_items.push_back(query(ModeEval, 0));
    drain();
    apb_write(1);
    pending_items.push_back(query(ModeEval, 0));
    drain();

    // Random phases over several counts, the extremes among them
    count_plan = '{2, 64, 127, 3, 8, 65, 5, 16, 2, 100, 4, 32};
    foreach (count_plan[p]) begin
      n_pts = (count_plan[p] > MaxPoints) ? MaxPoints : count_plan[p];
      load_table(n_pts, (p % 2) ? 32'h0200_0000 : 32'h0001_0000);
      drain();
      apb_write(count_plan[p]);
      for (int k = 0; k < 125; k++) begin
        case ($urandom_range(0, 19))
          0: pending_items.push_back(query(ModeValidate, $urandom));
          1: pending_items.push_back(query(ModeReserved, $urandom));
          2: pending_items.push_back(point_write($urandom_range(0, n_pts - 1),
                $signed($urandom), $signed($urandom), $signed($urandom),
                $signed($urandom)));
          3: pending_items.push_back(query(ModeEval, $urandom));
          default: pending_items.push_back(query(ModeEval,
                     shadow_x_hint(n_pts)));
        endcase
      end
      drain();
    end

    if (mismatches == 0 && expected_curve.size() == 0) begin
      $display("[bezier_spline_evaluator] OK");
    end else begin
      $display("[bezier_spline_evaluator] ERROR");
    end
    $finish;
  end
endmodule
